// ===== hdl/rle8pd_pkg.sv =====
// Shared types, codes and constants for the RLE8 palette bitmap decoder.
package rle8pd_pkg;

  localparam int unsigned MaxSide = 4096;
  localparam logic [12:0] SideLim = (MaxSide < 4096) ? 13'(MaxSide) : 13'd4096;

  localparam logic RegImageWidth  = 1'b0;
  localparam logic RegImageHeight = 1'b1;

  typedef enum logic [1:0] {
    KindRun = 2'd0,
    KindEol = 2'd1,
    KindEob = 2'd2,
    KindErr = 2'd3
  } kind_e;

  typedef enum logic [5:0] {
    PhFirst  = 6'b000001,
    PhSecond = 6'b000010,
    PhLit    = 6'b000100,
    PhPad    = 6'b001000,
    PhDeltaX = 6'b010000,
    PhDeltaY = 6'b100000
  } phase_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [11:0] row;
    logic [11:0] column;
    logic [7:0]  run_length;
  } res_t;

  function automatic logic [12:0] side_clamp(logic [12:0] v);
    logic [12:0] r;
    r = v;
    if (v == 13'd0) begin
      r = 13'd1;
    end else if (v > SideLim) begin
      r = SideLim;
    end
    return r;
  endfunction

endpackage

// ===== hdl/rle8pd_pal_ram.sv =====
// Palette memory: one write or one registered read per cycle.
module rle8pd_pal_ram #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic        re_i,
  input  logic [7:0]  index_i,
  input  logic [23:0] wdata_i,
  output logic [23:0] rdata_o
);

  localparam int unsigned AddrW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [23:0]      mem [PALETTE_ENTRIES];
  logic [23:0]      rd_q;
  logic             hit_q;
  logic             in_range;
  logic [AddrW-1:0] addr;

  assign in_range = ({1'b0, index_i} < 9'(PALETTE_ENTRIES));
  assign addr     = index_i[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (we_i && in_range) begin
      mem[addr] <= wdata_i;
    end
    if (re_i) begin
      rd_q  <= mem[addr];
      hit_q <= in_range;
    end
  end

  assign rdata_o = hit_q ? rd_q : 24'd0;

endmodule

// ===== hdl/rle8pd_parser.sv =====
// Stream parser: pair/escape phases, position tracking and image size registers.
module rle8pd_parser
  import rle8pd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output res_t        res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  fb_q, fb_d;
  logic [7:0]  lit_q, lit_d;
  logic        pad_q, pad_d;
  logic [11:0] row_q, row_d;
  logic [12:0] col_q, col_d;
  logic [12:0] w_q, w_d;
  logic [12:0] h_q, h_d;
  logic [13:0] run_end;
  res_t        res;

  assign run_end = {1'b0, col_q} + {6'd0, fb_q};

  always_comb begin
    phase_d = phase_q;
    fb_d    = fb_q;
    lit_d   = lit_q;
    pad_d   = pad_q;
    row_d   = row_q;
    col_d   = col_q;
    w_d     = w_q;
    h_d     = h_q;

    res            = '0;
    res.kind       = KindErr;
    res.row        = row_q;
    res.column     = col_q[11:0];

    if (step_i) begin
      case (phase_q)
        PhSecond: begin
          phase_d = PhFirst;
          if (fb_q != 8'd0) begin
            res.valid = 1'b1;
            if (run_end > {1'b0, w_q}) begin
              res.kind = KindErr;
            end else begin
              res.kind       = KindRun;
              res.run_length = fb_q;
              col_d          = run_end[12:0];
            end
          end else if (byte_i == 8'd0) begin
            res.valid = 1'b1;
            col_d     = 13'd0;
            if (row_q == 12'd0) begin
              res.kind = KindErr;
            end else begin
              res.kind = KindEol;
              row_d    = row_q - 12'd1;
            end
          end else if (byte_i == 8'd1) begin
            res.valid = 1'b1;
            res.kind  = KindEob;
            row_d     = 12'(h_q - 13'd1);
            col_d     = 13'd0;
          end else if (byte_i == 8'd2) begin
            res.valid = 1'b1;
            res.kind  = KindErr;
            phase_d   = PhDeltaX;
          end else begin
            lit_d   = byte_i;
            pad_d   = byte_i[0];
            phase_d = PhLit;
          end
        end
        PhLit: begin
          res.valid = 1'b1;
          if (col_q >= w_q) begin
            res.kind = KindErr;
          end else begin
            res.kind       = KindRun;
            res.run_length = 8'd1;
            col_d          = col_q + 13'd1;
          end
          lit_d = lit_q - 8'd1;
          if (lit_d == 8'd0) begin
            phase_d = pad_q ? PhPad : PhFirst;
          end
        end
        PhPad: begin
          pad_d   = 1'b0;
          phase_d = PhFirst;
        end
        PhDeltaX: phase_d = PhDeltaY;
        PhDeltaY: phase_d = PhFirst;
        default: begin
          fb_d    = byte_i;
          phase_d = PhSecond;
        end
      endcase
    end

    if (cfg_we_i) begin
      case (cfg_index_i)
        RegImageWidth: w_d = side_clamp(cfg_data_i);
        RegImageHeight: begin
          h_d   = side_clamp(cfg_data_i);
          row_d = 12'(h_d - 13'd1);
          col_d = 13'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
      fb_q    <= 8'd0;
      lit_q   <= 8'd0;
      pad_q   <= 1'b0;
      row_q   <= 12'd0;
      col_q   <= 13'd0;
      w_q     <= 13'd1;
      h_q     <= 13'd1;
    end else begin
      phase_q <= phase_d;
      fb_q    <= fb_d;
      lit_q   <= lit_d;
      pad_q   <= pad_d;
      row_q   <= row_d;
      col_q   <= col_d;
      w_q     <= w_d;
      h_q     <= h_d;
    end
  end

  assign res_o = res;

endmodule

// ===== hdl/rle8_palette_bitmap_decoder.sv =====
// RLE8 palette bitmap decoder: top level with result pipeline.
// A result passes the s1 register (with the palette read), then the output register.
// Throughput: one item per cycle while the output is not stalled; the parser
// updates in the accept cycle and the palette read completes in the next.
// Reset (async, active low) clears parse state, position, sizes (1 x 1) and
// valids; palette contents are undefined until written.
module rle8_palette_bitmap_decoder
  import rle8pd_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  palette_index_i,
  input  logic [7:0]  entry_red_i,
  input  logic [7:0]  entry_green_i,
  input  logic [7:0]  entry_blue_i,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [11:0] row_o,
  output logic [11:0] column_o,
  output logic [7:0]  run_length_o,
  output logic [7:0]  pixel_red_o,
  output logic [7:0]  pixel_green_o,
  output logic [7:0]  pixel_blue_o
);

  logic        in_acc;
  logic        s1_go;
  logic        s1_v_q;
  res_t        res;
  res_t        s1_q;
  logic [23:0] pal_rd;
  logic        out_v_q;
  res_t        out_q;
  logic [23:0] rgb_q;

  assign s1_go      = !out_v_q || out_ready_i;
  assign in_ready_o = !s1_v_q || s1_go;
  assign in_acc     = in_valid_i && in_ready_o;

  rle8pd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (in_acc && action_i),
    .byte_i      (stream_byte_i),
    .res_o       (res)
  );

  rle8pd_pal_ram #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_pal (
    .clk_i   (clk_i),
    .we_i    (in_acc && !action_i),
    .re_i    (in_acc && action_i),
    .index_i (action_i ? stream_byte_i : palette_index_i),
    .wdata_i ({entry_red_i, entry_green_i, entry_blue_i}),
    .rdata_o (pal_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
      if (s1_go) begin
        out_v_q <= s1_v_q && s1_q.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= res;
    end
    if (s1_go && s1_v_q) begin
      out_q <= s1_q;
      rgb_q <= (s1_q.kind == KindRun) ? pal_rd : 24'd0;
    end
  end

  assign out_valid_o   = out_v_q;
  assign kind_o        = out_q.kind;
  assign row_o         = out_q.row;
  assign column_o      = out_q.column;
  assign run_length_o  = out_q.run_length;
  assign pixel_red_o   = rgb_q[23:16];
  assign pixel_green_o = rgb_q[15:8];
  assign pixel_blue_o  = rgb_q[7:0];

endmodule

// ===== hdl/rle8pd_checker.sv =====
// Port-level checks for the RLE8 palette bitmap decoder, bound to the top level.
module rle8pd_checker
  import rle8pd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [11:0] row_o,
  input logic [11:0] column_o,
  input logic [7:0]  run_length_o,
  input logic [7:0]  pixel_red_o,
  input logic [7:0]  pixel_green_o,
  input logic [7:0]  pixel_blue_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(row_o)
      && $stable(column_o) && $stable(run_length_o))
    else $error("result item changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindRun |-> run_length_o != 8'd0)
    else $error("pixel run item with zero length");

  a_ctl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KindRun |-> run_length_o == 8'd0 && pixel_red_o == 8'd0
      && pixel_green_o == 8'd0 && pixel_blue_o == 8'd0)
    else $error("non-run item carries pixel data");

endmodule

bind rle8_palette_bitmap_decoder rle8pd_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .kind_o        (kind_o),
  .row_o         (row_o),
  .column_o      (column_o),
  .run_length_o  (run_length_o),
  .pixel_red_o   (pixel_red_o),
  .pixel_green_o (pixel_green_o),
  .pixel_blue_o  (pixel_blue_o)
);
